// ===== rtl/csv_fs_pkg.sv =====
// Shared types and constants for the CSV field splitter.
package csv_fs_pkg;

  localparam int unsigned ChW  = 8;
  localparam int unsigned CfgW = 6;
  localparam int unsigned IdxW = 5;

  localparam logic [ChW-1:0]  QuoteCh      = 8'h22;
  localparam logic [ChW-1:0]  CommaCh      = 8'h2C;
  localparam logic [CfgW-1:0] MaxFieldsRst = 6'd32;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_UNQ   = 3'd1,
    MODE_QUO   = 3'd2,
    MODE_QPEND = 3'd3,
    MODE_SKIP  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_LINE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           eol;
  } item_t;

  typedef struct packed {
    kind_e           kind;
    logic [ChW-1:0]  data_byte;
    logic [IdxW-1:0] field_index;
    logic            line_last;
  } res_t;

endpackage

// ===== rtl/csv_fs_in_reg.sv =====
// Input register stage that holds one incoming word until the parser takes it.
module csv_fs_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  csv_fs_pkg::item_t    item_i,
  output logic                 valid_o,
  input  logic                 take_i,
  output csv_fs_pkg::item_t    item_o
);

  logic              valid_q, valid_d;
  csv_fs_pkg::item_t item_q;

  // The stage refills in the same cycle that the parser drains it.
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/csv_fs_parser.sv =====
// Per-byte CSV parse state machine with its result register.
module csv_fs_parser #(
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [csv_fs_pkg::CfgW-1:0]         max_fields_i,
  input  logic                                valid_i,
  input  csv_fs_pkg::item_t                   item_i,
  output logic                                take_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output csv_fs_pkg::res_t                    res_o
);

  localparam int unsigned CntW = $clog2(MAX_COLS + 1);
  localparam int unsigned CmpW = (CntW > csv_fs_pkg::CfgW) ? CntW : csv_fs_pkg::CfgW;

  csv_fs_pkg::mode_e mode_q, mode_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  csv_fs_pkg::res_t  res_q, res_d;
  logic              has_res;
  logic [CmpW-1:0]   limit;
  logic              full;
  logic              is_quote, is_comma;

  // Results leave through a register, so a word is taken when that register frees up.
  assign take_o = valid_i && (!out_valid_q || out_ready_i);

  assign limit = (CmpW'(max_fields_i) > CmpW'(MAX_COLS)) ? CmpW'(MAX_COLS)
                                                           : CmpW'(max_fields_i);
  assign full     = CmpW'(count_q) >= limit;
  assign is_quote = item_i.ch == csv_fs_pkg::QuoteCh;
  assign is_comma = item_i.ch == csv_fs_pkg::CommaCh;

  always_comb begin
    mode_d              = mode_q;
    count_d             = count_q;
    has_res             = 1'b0;
    res_d.kind          = csv_fs_pkg::KIND_BYTE;
    res_d.data_byte     = item_i.ch;
    res_d.field_index   = csv_fs_pkg::IdxW'(count_q);
    res_d.line_last     = 1'b0;
    if (item_i.eol) begin
      has_res         = 1'b1;
      res_d.data_byte = '0;
      res_d.line_last = 1'b1;
      if (full) begin
        res_d.kind        = csv_fs_pkg::KIND_LINE;
        res_d.field_index = '0;
      end else begin
        res_d.kind = csv_fs_pkg::KIND_END;
      end
      mode_d  = csv_fs_pkg::MODE_START;
      count_d = '0;
    end else if (!full) begin
      case (mode_q)
        csv_fs_pkg::MODE_QUO: begin
          if (is_quote) begin
            mode_d = csv_fs_pkg::MODE_QPEND;
          end else begin
            has_res = 1'b1;
          end
        end
        csv_fs_pkg::MODE_QPEND: begin
          if (is_quote) begin
            mode_d  = csv_fs_pkg::MODE_QUO;
            has_res = 1'b1;
          end else if (is_comma) begin
            has_res = 1'b1;
          end else begin
            mode_d = csv_fs_pkg::MODE_SKIP;
          end
        end
        csv_fs_pkg::MODE_SKIP: begin
          has_res = is_comma;
        end
        csv_fs_pkg::MODE_UNQ: begin
          has_res = 1'b1;
        end
        default: begin
          if (is_quote) begin
            mode_d = csv_fs_pkg::MODE_QUO;
          end else begin
            has_res = 1'b1;
            if (!is_comma) begin
              mode_d = csv_fs_pkg::MODE_UNQ;
            end
          end
        end
      endcase
      // A comma that yields a result always closes the field, except inside quotes.
      if (is_comma && has_res && mode_q != csv_fs_pkg::MODE_QUO) begin
        res_d.kind      = csv_fs_pkg::KIND_END;
        res_d.data_byte = '0;
        mode_d          = csv_fs_pkg::MODE_START;
        count_d         = count_q + CntW'(1);
      end
    end
  end

  assign out_valid_d = take_o ? has_res : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= csv_fs_pkg::MODE_START;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        mode_q  <= mode_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && has_res) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/csv_field_splitter_top.sv =====
// Top level of the CSV field splitter: config register, input stage and parser.
//
//   Channel  Direction  Handshake               Word
//   cfg      in         cfg_we_i (no wait)      cfg_wdata_i = max_fields
//   in       in         in_valid_i / in_ready_o ch_i, eol_i
//   out      out        out_valid_o/out_ready_i kind_o, data_byte_o, field_index_o, line_last_o
//
// One input word is taken per cycle while the output is not stalled; a result passes
// through the input register and then the result register before it is presented.
// Reset clears the parse state and sets max_fields to 32.
// A stalled output holds its result; the input register keeps accepting until
// it holds a word that the parser cannot hand on.
module csv_field_splitter_top #(
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [csv_fs_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [csv_fs_pkg::ChW-1:0]       ch_i,
  input  logic                             eol_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       kind_o,
  output logic [csv_fs_pkg::ChW-1:0]       data_byte_o,
  output logic [csv_fs_pkg::IdxW-1:0]      field_index_o,
  output logic                             line_last_o
);

  logic [csv_fs_pkg::CfgW-1:0] max_fields_q;
  csv_fs_pkg::item_t           item_in, item_s1;
  logic                        s1_valid, s1_take;
  csv_fs_pkg::res_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fields_q <= csv_fs_pkg::MaxFieldsRst;
    end else if (cfg_we_i) begin
      max_fields_q <= cfg_wdata_i;
    end
  end

  assign item_in.ch  = ch_i;
  assign item_in.eol = eol_i;

  csv_fs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .valid_o    (s1_valid),
    .take_i     (s1_take),
    .item_o     (item_s1)
  );

  csv_fs_parser #(
    .MAX_COLS (MAX_COLS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_fields_i (max_fields_q),
    .valid_i      (s1_valid),
    .item_i       (item_s1),
    .take_o       (s1_take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign kind_o        = res.kind;
  assign data_byte_o   = res.data_byte;
  assign field_index_o = res.field_index;
  assign line_last_o   = res.line_last;

endmodule

// ===== sim/tb.sv =====
// Testbench for the CSV field splitter: directed and random lines checked against a line parser.
module tb;

  localparam int unsigned MaxCols    = 32;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned DrainPad   = 4;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [csv_fs_pkg::CfgW-1:0] cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [csv_fs_pkg::ChW-1:0]  ch_i;
  logic                        eol_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [1:0]                  kind_o;
  logic [csv_fs_pkg::ChW-1:0]  data_byte_o;
  logic [csv_fs_pkg::IdxW-1:0] field_index_o;
  logic                        line_last_o;

  csv_field_splitter_top #(
    .MAX_COLS(MaxCols)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .eol_i        (eol_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .field_index_o(field_index_o),
    .line_last_o  (line_last_o)
  );

  // Parser state as the block should hold it.
  csv_fs_pkg::mode_e           mode_q;
  logic [5:0]                  fields_done;
  logic [csv_fs_pkg::CfgW-1:0] field_limit_q;
  csv_fs_pkg::res_t            field_results_q[$];

  int          err_cnt     = 0;
  int unsigned words_taken = 0;
  bit          idle_on     = 1'b1;
  int unsigned hold_req    = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic close_field(output csv_fs_pkg::res_t r);
    r.kind        = csv_fs_pkg::KIND_END;
    r.data_byte   = '0;
    r.field_index = fields_done[csv_fs_pkg::IdxW-1:0];
    r.line_last   = 1'b0;
    fields_done   = fields_done + 6'd1;
    mode_q        = csv_fs_pkg::MODE_START;
  endtask

  // Advances the parser by one accepted word and queues the result it causes, if any.
  task automatic parse_word(input logic [csv_fs_pkg::ChW-1:0] c, input logic e);
    logic [csv_fs_pkg::CfgW-1:0] lim;
    bit                          full;
    bit                          emit;
    csv_fs_pkg::res_t            r;
    lim  = (field_limit_q > MaxCols) ? csv_fs_pkg::CfgW'(MaxCols) : field_limit_q;
    full = fields_done >= lim;
    emit = 1'b1;
    r.kind        = csv_fs_pkg::KIND_BYTE;
    r.data_byte   = c;
    r.field_index = fields_done[csv_fs_pkg::IdxW-1:0];
    r.line_last   = 1'b0;
    if (e) begin
      r.data_byte = '0;
      r.line_last = 1'b1;
      if (full) begin
        r.kind        = csv_fs_pkg::KIND_LINE;
        r.field_index = '0;
      end else begin
        r.kind = csv_fs_pkg::KIND_END;
      end
      mode_q      = csv_fs_pkg::MODE_START;
      fields_done = '0;
    end else if (full) begin
      emit = 1'b0;
    end else begin
      case (mode_q)
        csv_fs_pkg::MODE_QUO: begin
          if (c == csv_fs_pkg::QuoteCh) begin
            mode_q = csv_fs_pkg::MODE_QPEND;
            emit   = 1'b0;
          end
        end
        csv_fs_pkg::MODE_QPEND: begin
          // A second quote is an escaped quote; anything else closed the field.
          if (c == csv_fs_pkg::QuoteCh) begin
            mode_q = csv_fs_pkg::MODE_QUO;
          end else if (c == csv_fs_pkg::CommaCh) begin
            close_field(r);
          end else begin
            mode_q = csv_fs_pkg::MODE_SKIP;
            emit   = 1'b0;
          end
        end
        csv_fs_pkg::MODE_SKIP: begin
          if (c == csv_fs_pkg::CommaCh) close_field(r);
          else emit = 1'b0;
        end
        csv_fs_pkg::MODE_UNQ: begin
          if (c == csv_fs_pkg::CommaCh) close_field(r);
        end
        default: begin
          if (c == csv_fs_pkg::QuoteCh) begin
            mode_q = csv_fs_pkg::MODE_QUO;
            emit   = 1'b0;
          end else if (c == csv_fs_pkg::CommaCh) begin
            close_field(r);
          end else begin
            mode_q = csv_fs_pkg::MODE_UNQ;
          end
        end
      endcase
    end
    words_taken++;
    if (emit) field_results_q.push_back(r);
  endtask

  task automatic send_word(input logic [csv_fs_pkg::ChW-1:0] c, input logic e);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    eol_i      <= e;
    do @(posedge clk_i); while (!in_ready_o);
    parse_word(c, e);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Stops offering words and waits until the block has nothing left in flight.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (field_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [csv_fs_pkg::CfgW-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    field_limit_q = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [csv_fs_pkg::ChW-1:0] field_byte();
    logic [csv_fs_pkg::ChW-1:0] b;
    b = csv_fs_pkg::ChW'($urandom_range(0, 255));
    if (b == csv_fs_pkg::QuoteCh || b == csv_fs_pkg::CommaCh) b = 8'h5F;
    return b;
  endfunction

  task automatic send_field(input int unsigned len);
    if ($urandom_range(0, 9) < 4) begin
      send_word(csv_fs_pkg::QuoteCh, 1'b0);
      repeat (len) begin
        case ($urandom_range(0, 7))
          0: begin
            send_word(csv_fs_pkg::QuoteCh, 1'b0);
            send_word(csv_fs_pkg::QuoteCh, 1'b0);
          end
          1: send_word(csv_fs_pkg::CommaCh, 1'b0);
          default: send_word(field_byte(), 1'b0);
        endcase
      end
      send_word(csv_fs_pkg::QuoteCh, 1'b0);
      // Text after the closing quote is dropped up to the next comma.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_word(field_byte(), 1'b0);
      end
    end else begin
      for (int unsigned i = 0; i < len; i++) begin
        send_word((i != 0 && $urandom_range(0, 7) == 0) ? csv_fs_pkg::QuoteCh : field_byte(),
                  1'b0);
      end
    end
  endtask

  task automatic send_line(input int unsigned nfields, input int unsigned maxlen);
    for (int unsigned f = 0; f < nfields; f++) begin
      if (f != 0) send_word(csv_fs_pkg::CommaCh, 1'b0);
      send_field($urandom_range(0, maxlen));
    end
    if ($urandom_range(0, 9) == 0) send_word(csv_fs_pkg::CommaCh, 1'b0);
    send_word(csv_fs_pkg::ChW'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_noise_line();
    repeat ($urandom_range(0, 15)) begin
      case ($urandom_range(0, 3))
        0: send_word(csv_fs_pkg::QuoteCh, 1'b0);
        1: send_word(csv_fs_pkg::CommaCh, 1'b0);
        default: send_word(csv_fs_pkg::ChW'($urandom_range(0, 255)), 1'b0);
      endcase
    end
    send_word(csv_fs_pkg::ChW'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic run_random_lines(input logic [csv_fs_pkg::CfgW-1:0] limit,
                                  input int unsigned n_words);
    int unsigned stop_at;
    int unsigned pick;
    set_limit(limit);
    stop_at = words_taken + n_words;
    while (words_taken < stop_at) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
      if (pick < 15) send_noise_line();
      else if (pick < 20) send_line($urandom_range(30, 36), 1);
      else send_line($urandom_range(0, 6), 5);
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  task automatic test_quoting();
    // Empty quoted field closed by the line end, then an empty line.
    send_text("\"\"");
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b1);
    // Escaped quote, text after a closing quote, a quote inside a plain field,
    // the byte extremes, and a trailing comma.
    send_text("\"a\"\"b\"c,\"q\",x\"");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(csv_fs_pkg::CommaCh, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_limits();
    set_limit(6'd0);
    send_text("a");
    send_word(8'h7E, 1'b1);
    set_limit(6'd2);
    send_text("\"a\",b");
    // Lowering the limit mid-line cuts off the field already open.
    set_limit(6'd1);
    send_text("c");
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    set_limit(6'd32);
    idle_on  = 1'b0;
    hold_req = HoldCycles;
    repeat (4) send_line(4, 4);
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    run_random_lines(6'd32, 300);
    run_random_lines(6'd5, 200);
    run_random_lines(6'd1, 120);
    run_random_lines(6'd0, 40);
    run_random_lines(6'd63, 200);
    run_random_lines(6'd33, 150);
    run_random_lines(csv_fs_pkg::CfgW'($urandom_range(1, 32)), 200);
    run_random_lines(csv_fs_pkg::CfgW'($urandom_range(0, 63)), 100);
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (hold_req != 0) begin
        stall    = hold_req;
        hold_req = 0;
      end
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : result_check
    csv_fs_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (field_results_q.size() == 0) begin
        $error("unexpected word: kind %0d byte %0h index %0d last %0b",
               kind_o, data_byte_o, field_index_o, line_last_o);
        err_cnt++;
      end else begin
        want = field_results_q.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          err_cnt++;
        end
        if (data_byte_o !== want.data_byte) begin
          $error("data_byte: expected %0h, got %0h", want.data_byte, data_byte_o);
          err_cnt++;
        end
        if (field_index_o !== want.field_index) begin
          $error("field_index: expected %0d, got %0d", want.field_index, field_index_o);
          err_cnt++;
        end
        if (line_last_o !== want.line_last) begin
          $error("line_last: expected %0b, got %0b", want.line_last, line_last_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    ch_i          = '0;
    eol_i         = 1'b0;
    mode_q        = csv_fs_pkg::MODE_START;
    fields_done   = '0;
    field_limit_q = csv_fs_pkg::MaxFieldsRst;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_quoting();
    test_limits();
    test_backpressure();
    test_random();
    wait_drained();

    if (err_cnt == 0 && field_results_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
